// ===== rtl/core/kti_pkg.sv =====
// Shared types and codes for the keyframe track interpolator.
package kti_pkg;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Item kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SRCH_RD,
    CMD_SRCH_CMP,
    CMD_SHIFT_RD,
    CMD_SHIFT_WR,
    CMD_WRITE_NEW,
    CMD_RD_LEFT,
    CMD_RD_RIGHT,
    CMD_CAP_RIGHT,
    CMD_DIV_STEP,
    CMD_FINISH,
    CMD_OUTPUT
  } cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic flagged;
    logic search_busy;
    logic shift_busy;
    logic need_interp;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/kti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/kti_ctrl.sv =====
// Controller state machine sequencing search, shift, and division steps.
module kti_ctrl
  import kti_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_SRCH = 12'b000000000010,
    S_SCMP = 12'b000000000100,
    S_SHRD = 12'b000000001000,
    S_SHWR = 12'b000000010000,
    S_QL   = 12'b000000100000,
    S_QR   = 12'b000001000000,
    S_QCAP = 12'b000010000000,
    S_DIV  = 12'b000100000000,
    S_FIN  = 12'b001000000000,
    S_DONE = 12'b010000000000,
    S_SPARE = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat.flagged) begin
          state_nxt = S_DONE;
        end else if (stat.search_busy) begin
          cmd       = CMD_SRCH_RD;
          state_nxt = S_SCMP;
        end else if (stat.is_query) begin
          state_nxt = S_QL;
        end else begin
          state_nxt = S_SHRD;
        end
      end
      S_SCMP: begin
        cmd       = CMD_SRCH_CMP;
        state_nxt = S_SRCH;
      end
      S_SHRD: begin
        if (stat.shift_busy) begin
          cmd       = CMD_SHIFT_RD;
          state_nxt = S_SHWR;
        end else begin
          cmd       = CMD_WRITE_NEW;
          state_nxt = S_DONE;
        end
      end
      S_SHWR: begin
        cmd       = CMD_SHIFT_WR;
        state_nxt = S_SHRD;
      end
      S_QL: begin
        cmd       = CMD_RD_LEFT;
        state_nxt = S_QR;
      end
      S_QR: begin
        cmd       = CMD_RD_RIGHT;
        state_nxt = stat.need_interp ? S_QCAP : S_DONE;
      end
      S_QCAP: begin
        cmd       = CMD_CAP_RIGHT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd = CMD_DIV_STEP;
        if (stat.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd       = CMD_FINISH;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd       = CMD_OUTPUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/kti_dp.sv =====
// Datapath: keyframe table, search pointers, divider-multiplier, output register.
module kti_dp
  import kti_pkg::*;
#(
  parameter int MAX_KEYFRAMES = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output dp_stat_t    stat,
  input  logic        in_kind,
  input  logic [31:0] in_time,
  input  logic [31:0] in_weight,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_weight,
  output logic [1:0]  out_status
);

  localparam int AW   = $clog2(MAX_KEYFRAMES);
  localparam int CW   = AW + 1;
  localparam int ACCW = FRACTION_BITS + 33;
  localparam int DCW  = $clog2(FRACTION_BITS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_KEYFRAMES);

  logic              kind_r;
  logic [31:0]       t_r, w_r;
  logic [CW-1:0]     cnt_r, lo_r, hi_r, ptr_r;
  logic [31:0]       t0_r, w0_r, span_r;
  logic [32:0]       rem_r, mag_r;
  logic              neg_r;
  logic [ACCW-1:0]   acc_r;
  logic [DCW-1:0]    dcnt_r;
  logic [31:0]       res_r;
  logic [1:0]        stat_r;
  logic              ov_r;
  logic [31:0]       ow_r;
  logic [1:0]        os_r;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [63:0]       wdata, rdata;
  logic [CW-1:0]     mid;
  logic [31:0]       rd_time, rd_weight;
  logic [32:0]       rem2, dw;
  logic              ge;
  logic [32:0]       step;
  logic signed [34:0] sum;

  kti_ram #(.WIDTH(64), .DEPTH(MAX_KEYFRAMES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_time   = rdata[31:0];
  assign rd_weight = rdata[63:32];
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);

  // Memory port steering.
  always_comb begin
    we    = 1'b0;
    waddr = ptr_r[AW-1:0];
    wdata = rdata;
    raddr = mid[AW-1:0];
    unique case (cmd)
      CMD_SHIFT_RD: raddr = AW'(ptr_r - CW'(1));
      CMD_SHIFT_WR: we = 1'b1;
      CMD_WRITE_NEW: begin
        we    = 1'b1;
        waddr = lo_r[AW-1:0];
        wdata = {w_r, t_r};
      end
      CMD_RD_LEFT: begin
        if (lo_r >= cnt_r) begin
          raddr = AW'(cnt_r - CW'(1));
        end else if (lo_r == '0) begin
          raddr = '0;
        end else begin
          raddr = AW'(lo_r - CW'(1));
        end
      end
      CMD_RD_RIGHT: raddr = lo_r[AW-1:0];
      default: ;
    endcase
  end

  // Division and multiply step, one quotient bit per cycle.
  assign rem2 = {rem_r[31:0], 1'b0};
  assign ge   = (rem2 >= {1'b0, span_r});
  assign dw   = {rd_weight[31], rd_weight} - {w0_r[31], w0_r};
  assign step = acc_r[ACCW-1:FRACTION_BITS];
  assign sum  = neg_r ? ($signed({{3{w0_r[31]}}, w0_r}) - $signed({2'b00, step}))
                      : ($signed({{3{w0_r[31]}}, w0_r}) + $signed({2'b00, step}));

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (cmd == CMD_WRITE_NEW) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd == CMD_OUTPUT) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        kind_r <= in_kind;
        t_r    <= in_time;
        w_r    <= in_weight;
        lo_r   <= '0;
        hi_r   <= cnt_r;
        ptr_r  <= cnt_r;
        res_r  <= '0;
        if (in_kind == KIND_INSERT && cnt_r >= MAX_CNT) begin
          stat_r <= STAT_FULL;
        end else if (in_kind == KIND_QUERY && cnt_r == '0) begin
          stat_r <= STAT_EMPTY;
        end else begin
          stat_r <= STAT_OK;
        end
      end
      CMD_SRCH_CMP: begin
        if (rd_time <= t_r) begin
          lo_r <= mid + CW'(1);
        end else begin
          hi_r <= mid;
        end
      end
      CMD_SHIFT_WR: ptr_r <= ptr_r - CW'(1);
      CMD_RD_RIGHT: begin
        t0_r  <= rd_time;
        w0_r  <= rd_weight;
        res_r <= rd_weight;
        rem_r <= {1'b0, t_r - rd_time};
      end
      CMD_CAP_RIGHT: begin
        span_r <= rd_time - t0_r;
        neg_r  <= dw[32];
        mag_r  <= dw[32] ? (33'd0 - dw) : dw;
        acc_r  <= '0;
        dcnt_r <= DCW'(FRACTION_BITS);
      end
      CMD_DIV_STEP: begin
        rem_r  <= ge ? (rem2 - {1'b0, span_r}) : rem2;
        acc_r  <= (acc_r << 1) + (ge ? ACCW'(mag_r) : ACCW'(0));
        dcnt_r <= dcnt_r - DCW'(1);
      end
      CMD_FINISH: begin
        if (sum > 35'sd2147483647) begin
          res_r <= 32'h7fffffff;
        end else if (sum < -35'sd2147483648) begin
          res_r <= 32'h80000000;
        end else begin
          res_r <= sum[31:0];
        end
      end
      CMD_OUTPUT: begin
        ow_r <= res_r;
        os_r <= stat_r;
      end
      default: ;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    stat.is_query    = (kind_r == KIND_QUERY);
    stat.flagged     = (stat_r != STAT_OK);
    stat.search_busy = (lo_r < hi_r);
    stat.shift_busy  = (ptr_r > lo_r);
    stat.need_interp = (lo_r != '0) && (lo_r < cnt_r);
    stat.div_last    = (dcnt_r == DCW'(1));
    stat.out_free    = !ov_r || out_tready;
  end

  assign out_tvalid = ov_r;
  assign out_weight = ow_r;
  assign out_status = os_r;

endmodule

// ===== rtl/core/keyframe_track_interpolator.sv =====
// Insert time grows with the number of entries moved; query time is set mostly by
// the serial divide-multiply loop.
// Throughput: one item at a time; the next is taken once the result is
// registered, set by the single-port table walk and the bit-serial divider.
// Reset: synchronous active-low rst_n empties the table; contents are not cleared.
module keyframe_track_interpolator
  import kti_pkg::*;
#(
  parameter int MAX_KEYFRAMES = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] point_time, [63:32] point_weight
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_weight
  output logic [1:0]  out_tuser   // [1:0] status
);

  cmd_t     cmd;
  dp_stat_t stat;

  kti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kti_dp #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (in_tuser),
    .in_time    (in_tdata[31:0]),
    .in_weight  (in_tdata[63:32]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_weight (out_tdata),
    .out_status (out_tuser)
  );

  // A new transaction is never taken on the cycle right after one was accepted.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while busy");

  // A result is loaded only when the output register is free.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_OUTPUT) |-> (!out_tvalid || out_tready))
    else $error("result overwritten before transfer");

  // Status code three is never produced.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3))
    else $error("invalid status code");

endmodule

// ===== sim/tb_keyframe_track_interpolator.sv =====
// Self-checking testbench for the keyframe track interpolator: keyframe inserts and weight queries.
module tb_keyframe_track_interpolator;
  import kti_pkg::*;

  localparam int NUM_KEYS  = 64;
  localparam int FRAC_BITS = 16;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        kind;
    logic [31:0] point_time;
    logic [31:0] point_weight;
  } track_item_t;

  typedef struct packed {
    logic [31:0] result_weight;
    logic [1:0]  status;
  } track_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  track_item_t   pending_items[$];
  track_result_t expected_results[$];

  // Predictor copy of the keyframe table.
  logic [31:0] key_times[NUM_KEYS];
  logic [31:0] key_weights[NUM_KEYS];
  int          key_count;

  bit stim_done;
  bit failed;
  int idle_cycles;
  int send_gap;
  int recv_gap;

  keyframe_track_interpolator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] point_time, [63:32] point_weight
    .in_tuser   (in_tuser),   // [0] kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] result_weight
    .out_tuser  (out_tuser)   // [1:0] status
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Index of the first stored keyframe strictly later than the given time.
  function automatic int first_later_index(logic [31:0] t);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = key_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_times[mid] <= t) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Linear blend between neighbors idx-1 and idx, saturated to 32 bits.
  function automatic logic [31:0] blend_weight(logic [31:0] t, int idx);
    logic [63:0]        span;
    logic [63:0]        dt;
    logic [63:0]        blend;
    logic [63:0]        mag;
    logic [63:0]        step;
    logic signed [63:0] w0;
    logic signed [63:0] dw;
    logic signed [63:0] r;
    span = {32'd0, key_times[idx] - key_times[idx-1]};
    dt = {32'd0, t - key_times[idx-1]};
    w0 = {{32{key_weights[idx-1][31]}}, key_weights[idx-1]};
    dw = $signed({{32{key_weights[idx][31]}}, key_weights[idx]}) - w0;
    if (span == 0) return key_weights[idx-1];
    blend = (dt << FRAC_BITS) / span;
    mag = (dw < 0) ? 64'(-dw) : 64'(dw);
    step = (blend * mag) >> FRAC_BITS;
    r = (dw < 0) ? w0 - $signed(step) : w0 + $signed(step);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // Apply one item to the predicted table and return the expected result.
  function automatic track_result_t predict_track(track_item_t item);
    track_result_t res;
    int pos;
    res = '0;
    if (item.kind == KIND_INSERT) begin
      if (key_count >= NUM_KEYS) begin
        res.status = STAT_FULL;
      end else begin
        pos = first_later_index(item.point_time);
        for (int i = key_count; i > pos; i--) begin
          key_times[i] = key_times[i-1];
          key_weights[i] = key_weights[i-1];
        end
        key_times[pos] = item.point_time;
        key_weights[pos] = item.point_weight;
        key_count++;
      end
    end else if (key_count == 0) begin
      res.status = STAT_EMPTY;
    end else begin
      pos = first_later_index(item.point_time);
      if (pos >= key_count) res.result_weight = key_weights[key_count-1];
      else if (pos == 0) res.result_weight = key_weights[0];
      else res.result_weight = blend_weight(item.point_time, pos);
    end
    return res;
  endfunction

  function automatic int random_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic track_item_t make_item(logic kind, logic [31:0] t, logic [31:0] w);
    track_item_t item;
    item.kind = kind;
    item.point_time = t;
    item.point_weight = w;
    return item;
  endfunction

  // Append one item to the pending queue.
  function automatic void queue_item(track_item_t item);
    pending_items = {pending_items, item};
  endfunction

  // Stimulus: directed cases, then random phases that fill and query the table.
  initial begin
    key_count = 0;
    // Empty table query, then edge keyframes and equal-time inserts.
    queue_item(make_item(KIND_QUERY, 32'd100, 32'hFFFF_FFFF));
    queue_item(make_item(KIND_INSERT, 32'h0001_0000, 32'h8000_0000));
    queue_item(make_item(KIND_QUERY, 32'h0000_0000, 32'd0));
    queue_item(make_item(KIND_QUERY, 32'hFFFF_FFFF, 32'd0));
    queue_item(make_item(KIND_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    queue_item(make_item(KIND_QUERY, 32'h8000_0000, 32'd0));
    queue_item(make_item(KIND_QUERY, 32'hFFFF_FFFE, 32'd0));
    queue_item(make_item(KIND_QUERY, 32'h0001_0000, 32'd0));
    queue_item(make_item(KIND_INSERT, 32'h0001_0000, 32'h0000_1234));
    queue_item(make_item(KIND_INSERT, 32'h0002_0000, 32'hFFFF_0000));
    queue_item(make_item(KIND_QUERY, 32'h0001_8000, 32'd0));
    queue_item(make_item(KIND_QUERY, 32'h0000_0000, 32'd0));
    queue_item(make_item(KIND_QUERY, 32'hFFFF_FFFF, 32'd0));
    queue_item(make_item(KIND_INSERT, 32'h0000_0000, 32'h0000_0000));
    queue_item(make_item(KIND_QUERY, 32'h0000_8000, 32'd0));
    // Insert NUM_KEYS random keyframes, which fills the table and drops the surplus, then push one more dropped insert.
    for (int i = 0; i < NUM_KEYS; i++)
      queue_item(make_item(KIND_INSERT, $urandom(), $urandom()));
    queue_item(make_item(KIND_INSERT, 32'h1234_5678, 32'h7FFF_FFFF));
    // Random queries against the full table, with a few dropped inserts mixed in.
    for (int i = 0; i < 920; i++) begin
      if ($urandom_range(0, 9) == 0)
        queue_item(make_item(KIND_INSERT, random_word(), random_word()));
      else
        queue_item(make_item(KIND_QUERY, random_word(), random_word()));
    end
    foreach (pending_items[i])
      expected_results = {expected_results, predict_track(pending_items[i])};
    stim_done = 1'b1;
  end

  // Reset and end-of-run control.
  initial begin
    rst_n = 1'b0;
    failed = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Driver: present queued items with random gaps.
  initial begin
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    send_gap = 0;
    recv_gap = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        void'(pending_items.pop_front());
        send_gap = random_gap();
      end
      if ((!in_tvalid || in_tready) && send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap--;
      end else if (stim_done && pending_items.size() > 0 &&
                   !(in_tvalid && in_tready && pending_items.size() == 0)) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_items[0].point_weight, pending_items[0].point_time};
        in_tuser <= pending_items[0].kind;
      end else if (!in_tvalid || in_tready) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random output stalls and field-by-field comparison.
  always @(posedge clk) begin
    track_result_t exp_res;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: result_weight %h status %0d", out_tdata, out_tuser);
          failed = 1'b1;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_tdata !== exp_res.result_weight) begin
            $error("result_weight expected %h actual %h", exp_res.result_weight, out_tdata);
            failed = 1'b1;
          end
          if (out_tuser !== exp_res.status) begin
            $error("status expected %0d actual %0d", exp_res.status, out_tuser);
            failed = 1'b1;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_gap = random_gap();
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule
